// ----- rtl/core/wilder_smoothing_filter_unit_macros.svh -----
// assertion macros for the wilder smoothing filter unit
// no dependencies; the bodies are empty when SYNTHESIS is defined
`ifndef WILDER_SMOOTHING_FILTER_UNIT_MACROS_SVH
`define WILDER_SMOOTHING_FILTER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define WSF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wsf assertion failed");
// antecedent implies consequent in the next cycle
`define WSF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wsf assertion failed");
`else
`define WSF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define WSF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/wsf_pkg.sv -----
// shared constants and types for the wilder smoothing filter unit
// no dependencies
package wsf_pkg;

  localparam int unsigned PERIOD_BITS         = 8;
  localparam int unsigned SAMPLE_BITS_DEFAULT = 32;
  localparam int unsigned MAX_PERIOD          = 255;
  localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = PERIOD_BITS'(14);

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } wsf_stat_t;

endpackage

// ----- rtl/core/wsf_mul.sv -----
// bit-serial multiply-add: addend + mcand * mplier, one multiplier bit per cycle
// depends on wsf_pkg
module wsf_mul #(
  parameter int unsigned SAMPLE_BITS = wsf_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          start_i,
  input  logic [SAMPLE_BITS-1:0]                        mcand_i,
  input  logic [wsf_pkg::PERIOD_BITS-1:0]               mplier_i,
  input  logic [SAMPLE_BITS-1:0]                        addend_i,
  output wsf_pkg::wsf_stat_t                            stat_o,
  output logic [SAMPLE_BITS+wsf_pkg::PERIOD_BITS-1:0]   product_o
);

  localparam int unsigned PB  = wsf_pkg::PERIOD_BITS;
  localparam int unsigned ACC = SAMPLE_BITS + PB;
  localparam int unsigned CW  = $clog2(PB);

  logic [ACC-1:0] acc_q, mcand_q;
  logic [PB-1:0]  mplier_q;
  logic [CW-1:0]  cnt_q;
  logic           busy_q, done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(PB - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q    <= {{PB{addend_i[SAMPLE_BITS-1]}}, addend_i};
      mcand_q  <= {{PB{mcand_i[SAMPLE_BITS-1]}}, mcand_i};
      mplier_q <= mplier_i;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q  <= {mcand_q[ACC-2:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[PB-1:1]};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign product_o   = acc_q;

endmodule

// ----- rtl/core/wsf_div.sv -----
// radix-2 restoring divider, signed dividend by unsigned period, truncating toward zero
// depends on wsf_pkg
module wsf_div #(
  parameter int unsigned SAMPLE_BITS = wsf_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          start_i,
  input  logic [SAMPLE_BITS+wsf_pkg::PERIOD_BITS-1:0]   dividend_i,
  input  logic [wsf_pkg::PERIOD_BITS-1:0]               divisor_i,
  output wsf_pkg::wsf_stat_t                            stat_o,
  output logic [SAMPLE_BITS-1:0]                        quotient_o
);

  localparam int unsigned PB  = wsf_pkg::PERIOD_BITS;
  localparam int unsigned ACC = SAMPLE_BITS + PB;
  localparam int unsigned CW  = $clog2(ACC);

  logic [ACC-1:0]         dq_q, dq_d;
  logic [PB-1:0]          rem_q, rem_d, dvs_q;
  logic [PB:0]            trial, diff;
  logic                   ge;
  logic                   neg_q;
  logic [SAMPLE_BITS-1:0] quot_q;
  logic [CW-1:0]          cnt_q;
  logic                   busy_q, done_q;

  // one quotient bit per cycle
  always_comb begin
    trial = {rem_q, dq_q[ACC-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = (trial >= {1'b0, dvs_q});
    rem_d = ge ? diff[PB-1:0] : trial[PB-1:0];
    dq_d  = {dq_q[ACC-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(ACC - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[ACC-1];
      dq_q  <= dividend_i[ACC-1] ? (ACC'(0) - dividend_i) : dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
      if (cnt_q == CW'(ACC - 1)) begin
        quot_q <= neg_q ? (SAMPLE_BITS'(0) - dq_d[SAMPLE_BITS-1:0]) : dq_d[SAMPLE_BITS-1:0];
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quot_q;

endmodule

// ----- rtl/core/wilder_smoothing_filter_unit.sv -----
// Wilder smoothed moving average over signed fixed-point samples. The first N-1 samples of a
// series are summed as they are taken and give no result; the Nth gives their mean as the seed
// (tuser high), every later sample gives (previous*(N-1)+sample)/N, truncated toward zero.
// A sample with tuser (restart) set opens a new series. Arithmetic is bit-serial: the
// multiply by N-1 works through the period bits one at a time and the divide through the
// quotient bits one at a time; the next sample is taken once the result has moved into the
// output register, which then waits for the sink alone.
// depends on wsf_pkg, wsf_mul, wsf_div and wilder_smoothing_filter_unit_macros.svh
`include "wilder_smoothing_filter_unit_macros.svh"

module wilder_smoothing_filter_unit #(
  parameter int unsigned SAMPLE_BITS = wsf_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [wsf_pkg::PERIOD_BITS-1:0]       cfg_wdata_i,     // smoothing_period
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata_i,  // sample_value
  input  logic                                  s_axis_tuser_i,  // restart
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_axis_tdata_o,  // smoothed_value
  output logic                                  m_axis_tuser_o   // is_seed
);

  localparam int unsigned PB     = wsf_pkg::PERIOD_BITS;
  localparam int unsigned ACC    = SAMPLE_BITS + PB;
  localparam int unsigned DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned CAP_INT = (wsf_pkg::MAX_PERIOD < (2**PB - 1)) ?
                                    wsf_pkg::MAX_PERIOD : (2**PB - 1);
  localparam logic [PB-1:0] PERIOD_CAP = PB'(CAP_INT);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_HOLD
  } state_e;

  state_e                 state_q;
  logic [PB-1:0]          period_q, n_act, n_q;
  logic [PB-1:0]          seen_q, seen_eff, seen_inc;
  logic [ACC-1:0]         sum_q, sum_eff, sum_new;
  logic [SAMPLE_BITS-1:0] prev_q, prev_eff, sample;
  logic                   seed_q;
  logic [SAMPLE_BITS-1:0] out_data_q;
  logic                   out_seed_q, out_valid_q;
  logic                   in_acc, warm, last, out_free;

  wsf_pkg::wsf_stat_t     mul_stat, div_stat;
  logic [ACC-1:0]         mul_product, div_dividend;
  logic [SAMPLE_BITS-1:0] quotient;
  logic                   mul_start, div_start;

  always_comb begin
    if (period_q == '0) begin
      n_act = PB'(1);
    end else if (period_q > PERIOD_CAP) begin
      n_act = PERIOD_CAP;
    end else begin
      n_act = period_q;
    end
  end

  // restart clears the series state before the sample is taken
  always_comb begin
    sample   = s_axis_tdata_i[SAMPLE_BITS-1:0];
    seen_eff = s_axis_tuser_i ? '0 : seen_q;
    sum_eff  = s_axis_tuser_i ? '0 : sum_q;
    prev_eff = s_axis_tuser_i ? '0 : prev_q;
    warm     = (seen_eff < n_act);
    seen_inc = seen_eff + PB'(1);
    last     = (seen_inc == n_act);
    sum_new  = sum_eff + {{PB{sample[SAMPLE_BITS-1]}}, sample};
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign mul_start       = in_acc && !warm;
  assign div_start       = (in_acc && warm && last) || mul_stat.done;
  assign div_dividend    = mul_stat.done ? mul_product : sum_new;

  wsf_mul #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (prev_eff),
    .mplier_i (n_act - PB'(1)),
    .addend_i (sample),
    .stat_o   (mul_stat),
    .product_o(mul_product)
  );

  wsf_div #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (mul_stat.done ? n_q : n_act),
    .stat_o    (div_stat),
    .quotient_o(quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= wsf_pkg::PERIOD_RESET;
    end else if (cfg_we_i) begin
      period_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seen_q      <= '0;
      sum_q       <= '0;
      prev_q      <= '0;
      n_q         <= PB'(1);
      seed_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_seed_q  <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // in the hold state the output register is refilled instead
      if (out_valid_q && m_axis_tready_i && (state_q != ST_HOLD)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            n_q    <= n_act;
            prev_q <= prev_eff;
            if (warm) begin
              seen_q <= seen_inc;
              sum_q  <= sum_new;
              if (last) begin
                seed_q  <= 1'b1;
                state_q <= ST_DIV;
              end
            end else begin
              seed_q  <= 1'b0;
              state_q <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          if (mul_stat.done) begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state_q <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          // the result beat waits here until the output register is free
          if (out_free) begin
            out_data_q  <= quotient;
            out_seed_q  <= seed_q;
            out_valid_q <= 1'b1;
            prev_q      <= quotient;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = DATA_W'(out_data_q);
  assign m_axis_tuser_o  = out_seed_q;

  `WSF_ASSERT_IMP(a_mul_done_in_mul, clk_i, rst_ni, mul_stat.done, state_q == ST_MUL)
  `WSF_ASSERT_IMP(a_div_done_in_div, clk_i, rst_ni, div_stat.done, state_q == ST_DIV)
  `WSF_ASSERT_IMP(a_seed_after_warmup, clk_i, rst_ni, (state_q == ST_HOLD) && seed_q, seen_q == n_q)
  `WSF_ASSERT_NXT(a_smooth_starts_mul, clk_i, rst_ni, in_acc && !warm, mul_stat.busy && (state_q == ST_MUL))

endmodule
